// ===== rtl/erle_pkg.sv =====
// Package for the escape-byte run-length encoder.
// Holds the shared constants, the command types and the run flush function.
// No dependencies.
`default_nettype none

package erle_pkg;

  localparam int unsigned LenW = 16;
  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [7:0]      EscByte     = 8'hFF;
  localparam logic [7:0]      RunCap      = 8'd255;
  localparam logic [7:0]      MinRun      = 8'd3;
  localparam logic [LenW-1:0] MaxLenReset = 16'd1024;

  // One flushed run: n bytes to emit (0 to 3), as a triplet or as literals.
  typedef struct packed {
    logic [7:0] run_val;
    logic [7:0] count;
    logic [1:0] n;
    logic       trip;
  } seg_t;

  // Work handed from the front to the back for one accepted byte.
  typedef struct packed {
    seg_t            a;
    seg_t            b;
    logic [LenW-1:0] base;
    logic            last;
  } cmd_t;

  typedef struct packed {
    seg_t            seg;
    logic [LenW-1:0] em;
    logic            stopped;
  } flush_t;

  function automatic flush_t run_flush(input logic [7:0]      run_val,
                                       input logic [7:0]      count,
                                       input logic [LenW-1:0] em,
                                       input logic [LenW-1:0] max_len,
                                       input logic            stopped);
    flush_t r;
    r.seg.run_val = run_val;
    r.seg.count   = count;
    r.seg.n       = 2'd0;
    r.seg.trip    = 1'b0;
    r.em          = em;
    r.stopped     = stopped;
    if (count == 8'd0 || stopped) begin
      r.stopped = stopped;
    end else if (em >= max_len) begin
      r.stopped = 1'b1;
    end else if (count >= MinRun || run_val == EscByte) begin
      r.seg.trip = 1'b1;
      if ({1'b0, em} + 17'd3 > {1'b0, max_len}) begin
        r.stopped = 1'b1;
      end else begin
        r.seg.n = 2'd3;
        r.em    = em + 16'd3;
        if (r.em >= max_len) begin
          r.stopped = 1'b1;
        end
      end
    end else begin
      if (count == 8'd2 && (max_len - em) >= 16'd2) begin
        r.seg.n = 2'd2;
      end else begin
        r.seg.n = 2'd1;
      end
      r.em = em + {14'd0, r.seg.n};
      if (r.em >= max_len) begin
        r.stopped = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/erle_if.sv =====
// Valid/ready channel interfaces of the escape-byte run-length encoder.
// Input bytes, configuration writes and output results. No dependencies.
`default_nettype none

interface erle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface erle_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_output_len;
  modport source (output valid, max_output_len, input ready);
  modport sink (input valid, max_output_len, output ready);
endinterface

interface erle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        out_last;
  logic [15:0] out_len;
  modport source (output valid, out_byte, byte_valid, out_last, out_len, input ready);
  modport sink (input valid, out_byte, byte_valid, out_last, out_len, output ready);
endinterface

`default_nettype wire

// ===== rtl/escape_rle_encoder.sv =====
// Escape-byte run-length encoder. A front stage accepts one raw byte per cycle
// while its command queue has room, and a back stage sends one output byte per
// cycle while the output is ready. Each input byte yields zero to six output
// bytes, so the sustained input rate is set by the output port. Depends on
// erle_pkg, erle_if, erle_front, erle_fifo and erle_back.
`default_nettype none

module escape_rle_encoder
  import erle_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  erle_in_if.sink   in_i,
  erle_cfg_if.sink  cfg_i,
  erle_out_if.source out_o
);

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_valid;

  assign cfg_i.ready = 1'b1;

  erle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_byte_i  (in_i.in_byte),
    .in_last_i  (in_i.in_last),
    .cfg_valid_i(cfg_i.valid),
    .cfg_data_i (cfg_i.max_output_len),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  erle_fifo #(
    .Width($bits(cmd_t)),
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .data_o (cmd_out)
  );

  erle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .byte_valid_o(out_o.byte_valid),
    .out_last_o  (out_o.out_last),
    .out_len_o   (out_o.out_len)
  );

endmodule

`default_nettype wire

// ===== rtl/erle_front.sv =====
// Front of the encoder: tracks runs, budget and stop state, and emits commands.
// Depends on erle_pkg.
`default_nettype none

module erle_front
  import erle_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            in_last_i,
  input  wire logic            cfg_valid_i,
  input  wire logic [LenW-1:0] cfg_data_i,
  output logic                 cmd_push_o,
  output cmd_t                 cmd_o,
  input  wire logic            cmd_full_i
);

  logic [7:0]      run_val_q, run_val_d;
  logic [7:0]      run_cnt_q, run_cnt_d;
  logic [LenW-1:0] em_q, em_d;
  logic            stopped_q, stopped_d;
  logic [LenW-1:0] max_len_q;

  logic            accept;
  logic            extend;
  logic [7:0]      val1, cnt1;
  logic [LenW-1:0] em1;
  logic            stop1;
  flush_t          fa, fb;
  seg_t            seg_a, seg_b;

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    extend = (run_cnt_q != 8'd0) && (in_byte_i == run_val_q) && (run_cnt_q != RunCap);
    fa     = run_flush(run_val_q, run_cnt_q, em_q, max_len_q, stopped_q);
    seg_a  = fa.seg;
    seg_a.n = 2'd0;
    val1   = run_val_q;
    cnt1   = run_cnt_q;
    em1    = em_q;
    stop1  = stopped_q;
    if (!stopped_q) begin
      if (extend) begin
        cnt1 = run_cnt_q + 8'd1;
      end else begin
        seg_a = fa.seg;
        em1   = fa.em;
        stop1 = fa.stopped;
        cnt1  = 8'd0;
        if (!fa.stopped) begin
          val1 = in_byte_i;
          cnt1 = 8'd1;
        end
      end
    end
    fb    = run_flush(val1, cnt1, em1, max_len_q, stop1);
    seg_b = fb.seg;
    if (!in_last_i) begin
      seg_b.n = 2'd0;
    end

    cmd_o.a    = seg_a;
    cmd_o.b    = seg_b;
    cmd_o.base = em_q;
    cmd_o.last = in_last_i;
    cmd_push_o = accept && (seg_a.n != 2'd0 || in_last_i);

    run_val_d = run_val_q;
    run_cnt_d = run_cnt_q;
    em_d      = em_q;
    stopped_d = stopped_q;
    if (accept) begin
      if (in_last_i) begin
        run_val_d = 8'd0;
        run_cnt_d = 8'd0;
        em_d      = '0;
        stopped_d = 1'b0;
      end else begin
        run_val_d = val1;
        run_cnt_d = cnt1;
        em_d      = em1;
        stopped_d = stop1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_val_q <= 8'd0;
      run_cnt_q <= 8'd0;
      em_q      <= '0;
      stopped_q <= 1'b0;
      max_len_q <= MaxLenReset;
    end else begin
      run_val_q <= run_val_d;
      run_cnt_q <= run_cnt_d;
      em_q      <= em_d;
      stopped_q <= stopped_d;
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/erle_fifo.sv =====
// Small register FIFO that holds commands between the front and the back.
// No package dependencies.
`default_nettype none

module erle_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [Width-1:0]      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("FIFO count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   full_o && !do_pop |=> full_o)
    else $error("FIFO lost an entry while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !valid_o && !push_i |=> !valid_o)
    else $error("FIFO invented an entry");

endmodule

`default_nettype wire

// ===== rtl/erle_back.sv =====
// Back of the encoder: expands commands into output bytes, one per cycle while the output is ready.
// Depends on erle_pkg.
`default_nettype none

module erle_back
  import erle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  input  wire cmd_t       cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            out_last_o,
  output logic [LenW-1:0] out_len_o
);

  logic [2:0]      idx_q;
  logic            ov_q;
  logic [7:0]      byte_q;
  logic            bv_q, last_q;
  logic [LenW-1:0] len_q;

  logic [2:0]      total;
  logic            marker, final_byte, load;
  seg_t            seg;
  logic [2:0]      k;
  logic [7:0]      nxt_byte;
  logic [LenW-1:0] nxt_len;

  always_comb begin
    total      = {1'b0, cmd_i.a.n} + {1'b0, cmd_i.b.n};
    marker     = (total == 3'd0);
    final_byte = marker || (idx_q == total - 3'd1);
    if (idx_q < {1'b0, cmd_i.a.n}) begin
      seg = cmd_i.a;
      k   = idx_q;
    end else begin
      seg = cmd_i.b;
      k   = idx_q - {1'b0, cmd_i.a.n};
    end
    if (seg.trip && k == 3'd0) begin
      nxt_byte = EscByte;
    end else if (seg.trip && k == 3'd1) begin
      nxt_byte = seg.count;
    end else begin
      nxt_byte = seg.run_val;
    end
    nxt_len = cmd_i.base + {13'd0, idx_q} + 16'd1;
    if (marker) begin
      nxt_byte = 8'd0;
      nxt_len  = cmd_i.base;
    end
    load      = cmd_valid_i && (!ov_q || out_ready_i);
    cmd_pop_o = load && final_byte;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= nxt_byte;
      bv_q   <= !marker;
      last_q <= cmd_i.last && final_byte;
      len_q  <= nxt_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= final_byte ? 3'd0 : idx_q + 3'd1;
        ov_q  <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bv_q;
  assign out_last_o   = last_q;
  assign out_len_o    = len_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && !byte_valid_o |-> out_last_o)
    else $error("Marker result without last flag");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_valid_i && marker |-> cmd_i.last)
    else $error("Empty command that does not end a block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   idx_q != 3'd0 |-> cmd_valid_i)
    else $error("Expansion in progress without a command");

endmodule

`default_nettype wire
